@@ design/drsc_pkg.sv @@
package drsc_pkg;

  // Stream codes
  localparam logic [7:0] FLAG_RUN    = 8'h80;
  localparam logic [7:0] FLAG_SINGLE = 8'h00;
  localparam logic [7:0] FLAG_RAW    = 8'hC0;
  localparam logic [7:0] RUN_MAX     = 8'd255;

  // Sizes
  localparam int JOB_BYTES   = 6;
  localparam int QUEUE_DEPTH = 4;

  // Bytes caused by one sample, first byte at index 0
  typedef struct packed {
    logic [0:JOB_BYTES-1][7:0] bytes;
    logic [2:0]                count;
    logic                      eob;
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    job_t head;
    logic empty;
  } queue_status_t;

endpackage

@@ design/drsc_front.sv @@
module drsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               full,
  input  logic signed [15:0] sample,
  input  logic [15:0]        block_count,
  output logic               push,
  output drsc_pkg::job_t     job
);
  import drsc_pkg::*;

  logic [15:0] previous_sample, previous_sample_next;
  logic [7:0]  run_delta, run_delta_next;
  logic [7:0]  group_len, group_len_next;
  logic [15:0] samples_left, samples_left_next;
  logic        in_block, in_block_next;

  logic [16:0] delta;
  logic [7:0]  d8;
  logic        small_delta;
  logic        extend;
  logic        block_end;
  logic [1:0]  fl, tl;
  logic [0:2][7:0] fb, tb;
  logic        take;

  assign take = in_valid && !full;

  // Classify the sample and assemble its transaction bytes
  always_comb begin
    delta       = {sample[15], sample} - {previous_sample[15], previous_sample};
    d8          = delta[7:0];
    small_delta = (delta[16:7] == '0) || (delta[16:7] == '1);
    extend      = small_delta && (group_len != 8'd0) && (group_len != RUN_MAX) &&
                  (d8 == run_delta);
    block_end   = (samples_left == 16'd1);

    previous_sample_next = previous_sample;
    run_delta_next       = run_delta;
    group_len_next       = group_len;
    samples_left_next    = samples_left;
    in_block_next        = in_block;

    fb = '0;
    tb = '0;
    fl = 2'd0;
    tl = 2'd0;
    job = '0;
    push = 1'b0;

    if (!in_block) begin
      // Header sample
      job.bytes = {block_count[15:8], block_count[7:0], sample[15:8], sample[7:0], 16'h0};
      job.count = 3'd4;
      job.eob   = (block_count == 16'd1);
      if (block_count != 16'd0) begin
        push                 = take;
        previous_sample_next = sample;
        group_len_next       = 8'd0;
        run_delta_next       = 8'd0;
        samples_left_next    = block_count - 16'd1;
        in_block_next        = (block_count != 16'd1);
      end
    end else begin
      // Flush of the pending group, unless this sample extends it
      if (!extend) begin
        if (group_len > 8'd1) begin
          fb = {FLAG_RUN, run_delta, group_len};
          fl = 2'd3;
        end else if (group_len == 8'd1) begin
          fb = {FLAG_SINGLE, run_delta, 8'h0};
          fl = 2'd2;
        end
      end

      // Raw sample or end-of-block flush of the new group
      if (extend) begin
        group_len_next = group_len + 8'd1;
        if (block_end) begin
          tb = {FLAG_RUN, run_delta, group_len + 8'd1};
          tl = 2'd3;
        end
      end else if (small_delta) begin
        run_delta_next = d8;
        group_len_next = 8'd1;
        if (block_end) begin
          tb = {FLAG_SINGLE, d8, 8'h0};
          tl = 2'd2;
        end
      end else begin
        group_len_next = 8'd0;
        tb = {FLAG_RAW, sample[15:8], sample[7:0]};
        tl = 2'd3;
      end

      unique case (fl)
        2'd2:    job.bytes = {fb[0], fb[1], tb[0], tb[1], tb[2], 8'h0};
        2'd3:    job.bytes = {fb[0], fb[1], fb[2], tb[0], tb[1], tb[2]};
        default: job.bytes = {tb[0], tb[1], tb[2], 24'h0};
      endcase
      job.count = {1'b0, fl} + {1'b0, tl};
      job.eob   = block_end;
      push      = take && (job.count != 3'd0);

      previous_sample_next = sample;
      samples_left_next    = samples_left - 16'd1;
      if (block_end) begin
        group_len_next = 8'd0;
        in_block_next  = 1'b0;
      end
    end
  end

  // Advance block state on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      run_delta       <= '0;
      group_len       <= '0;
      samples_left    <= '0;
      in_block        <= 1'b0;
    end else if (take) begin
      previous_sample <= previous_sample_next;
      run_delta       <= run_delta_next;
      group_len       <= group_len_next;
      samples_left    <= samples_left_next;
      in_block        <= in_block_next;
    end
  end

endmodule

@@ design/drsc_queue.sv @@
module drsc_queue #(
  parameter int DEPTH = drsc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  drsc_pkg::job_t          push_job,
  input  logic                    pop,
  output logic                    full,
  output drsc_pkg::queue_status_t status
);
  import drsc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   fill;

  assign full         = (fill == CW'(DEPTH));
  assign status.empty = (fill == '0);
  assign status.head  = entries[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ design/drsc_back.sv @@
module drsc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  drsc_pkg::queue_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_of_item,
  output logic                    end_of_block
);
  import drsc_pkg::*;

  logic [2:0] idx;
  logic       advance;
  logic       last_sel;
  logic [7:0] byte_sel;

  assign advance  = !out_valid || !out_stall;
  assign last_sel = (idx == status.head.count - 3'd1);
  assign pop      = advance && !status.empty && last_sel;

  // Pick the current byte of the head transaction
  always_comb begin
    unique case (idx)
      3'd0:    byte_sel = status.head.bytes[0];
      3'd1:    byte_sel = status.head.bytes[1];
      3'd2:    byte_sel = status.head.bytes[2];
      3'd3:    byte_sel = status.head.bytes[3];
      3'd4:    byte_sel = status.head.bytes[4];
      3'd5:    byte_sel = status.head.bytes[5];
      default: byte_sel = 8'h0;
    endcase
  end

  // Load the output register one byte at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= !status.empty;
      if (!status.empty) begin
        idx <= last_sel ? 3'd0 : idx + 3'd1;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (advance && !status.empty) begin
      out_byte     <= byte_sel;
      last_of_item <= last_sel;
      end_of_block <= last_sel && status.head.eob;
    end
  end

endmodule

@@ design/delta_run_sample_compressor_unit.sv @@
// Channel  Handshake              Payload
// input    in_valid / in_stall    sample, block_count
// output   out_valid / out_stall  out_byte, last_of_item, end_of_block
//
// The front end classifies one sample per cycle while the queue is not full and queues
// its bytes as one transaction. The back end sends one byte per cycle while the queue
// holds bytes and out_stall is low; a sample's bytes pass through the queue and then the
// output register. A sample causes none to 6 bytes; the byte rate sets the sustained rate.
// Synchronous reset clears block state, the queue and the output valid flag.
// in_stall rises only while the queue is full; out_stall holds the output register.
module delta_run_sample_compressor_unit #(
  parameter int QUEUE_DEPTH = drsc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic [15:0]        block_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last_of_item,
  output logic               end_of_block
);
  import drsc_pkg::*;

  logic          push;
  logic          pop;
  logic          full;
  job_t          job;
  queue_status_t status;

  assign in_stall = full;

  drsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .full        (full),
    .sample      (sample),
    .block_count (block_count),
    .push        (push),
    .job         (job)
  );

  drsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .status   (status)
  );

  drsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .status       (status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .end_of_block (end_of_block)
  );

endmodule
